@@ sv/bxt_pkg.sv @@
// bxt_pkg: shared constants, request and status codes, and the command and
// flag structs between the trie controller and the trie datapath
// depends on nothing
`default_nettype none

package bxt_pkg;

   // default sizes for the top level and datapath parameters
   localparam int KEY_BITS_DEF   = 32;
   localparam int POOL_NODES_DEF = 4096;
   localparam int TALLY_BITS_DEF = 16;

   // fixed payload widths
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 2;
   localparam int WORD_W   = 32;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_MAX    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_MIN    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // datapath operations, one per cycle, OP_NONE while the controller waits or stalls
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_INS_LINK,
      OP_INS_TALLY,
      OP_INS_NEW,
      OP_REM_LINK,
      OP_REM_UP_RD,
      OP_REM_UP_WR,
      OP_EXT_LINK,
      OP_CNT_LINK,
      OP_CNT_ADD,
      OP_CNT_FIN,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req;
      logic             full;
      logic             empty;
      logic             thr_wide;
      logic             lvl_last;
      logic             lvl_top;
      logic             child_null;
      logic             ext_null;
      logic             next_null;
   } flags_type;

endpackage

`default_nettype wire

@@ sv/bxt_if.sv @@
// bxt_req_if and bxt_rsp_if: valid/ready channels for request and result words
// depends on nothing
`default_nettype none

interface bxt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] value;
   logic [31:0] threshold;

   modport source (output valid, output req_type, output value, output threshold,
                   input ready);
   modport sink   (input valid, input req_type, input value, input threshold,
                   output ready);
endinterface

interface bxt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] answer;

   modport source (output valid, output status, output answer, input ready);
   modport sink   (input valid, input status, input answer, output ready);
endinterface

`default_nettype wire

@@ sv/bxt_datapath.sv @@
// bxt_datapath: node memories, free stack, path stack and walk registers
// depends on bxt_pkg
`default_nettype none

module bxt_datapath #(
   parameter int KEY_BITS   = bxt_pkg::KEY_BITS_DEF,
   parameter int POOL_NODES = bxt_pkg::POOL_NODES_DEF,
   parameter int TALLY_BITS = bxt_pkg::TALLY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bxt_pkg::cmd_type                   cmd,
   input  logic [bxt_pkg::REQ_W-1:0]          in_req_type,
   input  logic [bxt_pkg::WORD_W-1:0]         in_value,
   input  logic [bxt_pkg::WORD_W-1:0]         in_threshold,
   output bxt_pkg::flags_type                 flags,
   output logic [bxt_pkg::STATUS_W-1:0]       out_status,
   output logic [bxt_pkg::WORD_W-1:0]         out_answer
);

   localparam int NODE_W  = $clog2(POOL_NODES);
   localparam int DEPTH_W = NODE_W + 1;
   localparam int LVL_W   = $clog2(KEY_BITS);

   // memories
   logic [NODE_W-1:0]     zero_mem  [POOL_NODES];
   logic [NODE_W-1:0]     one_mem   [POOL_NODES];
   logic [TALLY_BITS-1:0] tally_mem [POOL_NODES];
   logic [NODE_W-1:0]     stack_mem [POOL_NODES];
   logic [NODE_W-1:0]     path_ff   [KEY_BITS];

   // registered read data
   logic [NODE_W-1:0]     zero_rd_ff, one_rd_ff, top_rd_ff;
   logic [TALLY_BITS-1:0] tally_rd_ff;

   // walk registers
   logic [bxt_pkg::REQ_W-1:0]    req_ff, req_in;
   logic [bxt_pkg::WORD_W-1:0]   value_ff, value_in, thr_ff, thr_in;
   logic [NODE_W-1:0]            cur_ff, cur_in, nx_ff, nx_in, par_ff, par_in;
   logic [LVL_W-1:0]             lvl_ff, lvl_in;
   logic [bxt_pkg::WORD_W-1:0]   acc_ff, acc_in;
   logic [bxt_pkg::STATUS_W-1:0] st_ff, st_in;
   logic                         fresh_ff, fresh_in, pend_ff, pend_in;
   logic [DEPTH_W-1:0]           depth_ff, depth_in, low_ff, low_in;
   logic [TALLY_BITS-1:0]        total_ff, total_in;
   logic [NODE_W-1:0]            root0_ff, root0_in, root1_ff, root1_in;
   logic [bxt_pkg::STATUS_W-1:0] out_status_ff;
   logic [bxt_pkg::WORD_W-1:0]   out_answer_ff;
   logic                         emit;

   // write ports
   logic                  zero_we, one_we, tally_we, stack_we, path_we;
   logic [NODE_W-1:0]     zero_wa, one_wa, tally_wa, stack_wa;
   logic [NODE_W-1:0]     zero_wd, one_wd, stack_wd, path_wd;
   logic [TALLY_BITS-1:0] tally_wd;
   logic [NODE_W-1:0]     tally_ra, top_ra;

   // walk decode
   logic [NODE_W-1:0]     link0, link1, child_v, pref_child, alt_child, ext_nx;
   logic [NODE_W-1:0]     over, cnt_nx, top_val;
   logic                  vbit, kbit, pref, took;
   logic [TALLY_BITS-1:0] tally_dec;
   logic [LVL_W-1:0]      par_idx;
   logic [DEPTH_W-1:0]    depth_dn;

   assign link0 = (cur_ff == '0) ? root0_ff : (fresh_ff ? '0 : zero_rd_ff);
   assign link1 = (cur_ff == '0) ? root1_ff : (fresh_ff ? '0 : one_rd_ff);
   assign vbit  = value_ff[lvl_ff];
   assign kbit  = thr_ff[lvl_ff];
   assign child_v    = vbit ? link1 : link0;
   assign pref       = vbit ^ (req_ff == bxt_pkg::REQ_MAX);
   assign pref_child = pref ? link1 : link0;
   assign alt_child  = pref ? link0 : link1;
   assign took       = (pref_child != '0) ? pref : ~pref;
   assign ext_nx     = (pref_child != '0) ? pref_child : alt_child;
   assign over       = vbit ? link0 : link1;
   assign cnt_nx     = (vbit ^ kbit) ? link1 : link0;
   // never-touched stack slots are not read: at or below the low-water mark the depth itself names the free node
   assign top_val    = (depth_ff <= low_ff) ? depth_ff[NODE_W-1:0] : top_rd_ff;
   assign tally_dec  = tally_rd_ff - 1'b1;
   assign par_idx    = lvl_ff + 1'b1;
   assign depth_dn   = depth_ff - 1'b1;

   assign flags.req        = req_ff;
   assign flags.full       = (depth_ff < DEPTH_W'(KEY_BITS)) || (&total_ff);
   assign flags.empty      = (total_ff == '0);
   assign flags.thr_wide   = |(thr_ff >> KEY_BITS);
   assign flags.lvl_last   = (lvl_ff == '0);
   assign flags.lvl_top    = (lvl_ff == LVL_W'(KEY_BITS - 1));
   assign flags.child_null = (child_v == '0);
   assign flags.ext_null   = (ext_nx == '0);
   assign flags.next_null  = (nx_ff == '0);

   always_comb begin
      req_in   = req_ff;
      value_in = value_ff;
      thr_in   = thr_ff;
      cur_in   = cur_ff;
      nx_in    = nx_ff;
      par_in   = par_ff;
      lvl_in   = lvl_ff;
      acc_in   = acc_ff;
      st_in    = st_ff;
      fresh_in = fresh_ff;
      pend_in  = pend_ff;
      depth_in = depth_ff;
      total_in = total_ff;
      root0_in = root0_ff;
      root1_in = root1_ff;
      zero_we  = 1'b0;
      zero_wa  = cur_ff;
      zero_wd  = '0;
      one_we   = 1'b0;
      one_wa   = cur_ff;
      one_wd   = '0;
      tally_we = 1'b0;
      tally_wa = cur_ff;
      tally_wd = '0;
      tally_ra = cur_ff;
      stack_we = 1'b0;
      stack_wa = depth_ff[NODE_W-1:0];
      stack_wd = cur_ff;
      path_we  = 1'b0;
      path_wd  = child_v;
      emit     = 1'b0;
      case (cmd.op)
         bxt_pkg::OP_LOAD: begin
            req_in   = in_req_type;
            value_in = in_value;
            thr_in   = in_threshold;
            cur_in   = '0;
            lvl_in   = LVL_W'(KEY_BITS - 1);
            acc_in   = '0;
            st_in    = bxt_pkg::ST_OK;
            fresh_in = 1'b0;
            pend_in  = 1'b0;
         end
         bxt_pkg::OP_CHECK: begin
            if (req_ff == bxt_pkg::REQ_INSERT && flags.full)
               st_in = bxt_pkg::ST_FULL;
            if ((req_ff == bxt_pkg::REQ_MAX || req_ff == bxt_pkg::REQ_MIN) && flags.empty)
               st_in = bxt_pkg::ST_EMPTY;
         end
         bxt_pkg::OP_INS_LINK: begin
            if (child_v != '0) begin
               cur_in   = child_v;
               fresh_in = 1'b0;
               tally_ra = child_v;
            end else begin
               depth_in = depth_dn;
               cur_in   = top_val;
               if (cur_ff == '0) begin
                  if (vbit) root1_in = top_val;
                  else      root0_in = top_val;
               end else if (vbit) begin
                  one_we = 1'b1;
                  one_wd = top_val;
               end else begin
                  zero_we = 1'b1;
                  zero_wd = top_val;
               end
            end
         end
         bxt_pkg::OP_INS_TALLY: begin
            tally_we = 1'b1;
            tally_wd = tally_rd_ff + 1'b1;
            if (flags.lvl_last) total_in = total_ff + 1'b1;
            else                lvl_in   = lvl_ff - 1'b1;
         end
         bxt_pkg::OP_INS_NEW: begin
            zero_we  = 1'b1;
            one_we   = 1'b1;
            tally_we = 1'b1;
            tally_wd = TALLY_BITS'(1);
            fresh_in = 1'b1;
            if (flags.lvl_last) total_in = total_ff + 1'b1;
            else                lvl_in   = lvl_ff - 1'b1;
         end
         bxt_pkg::OP_REM_LINK: begin
            if (child_v == '0) begin
               st_in = bxt_pkg::ST_NOTFOUND;
            end else begin
               path_we = 1'b1;
               cur_in  = child_v;
               if (!flags.lvl_last) lvl_in = lvl_ff - 1'b1;
            end
         end
         bxt_pkg::OP_REM_UP_RD: begin
            tally_ra = cur_ff;
            par_in   = flags.lvl_top ? '0 : path_ff[par_idx];
         end
         bxt_pkg::OP_REM_UP_WR: begin
            tally_we = 1'b1;
            tally_wd = tally_dec;
            if (tally_dec == '0) begin
               // unlink from the parent and return the node to the free stack
               if (par_ff == '0) begin
                  if (vbit) root1_in = '0;
                  else      root0_in = '0;
               end else if (vbit) begin
                  one_we = 1'b1;
                  one_wa = par_ff;
               end else begin
                  zero_we = 1'b1;
                  zero_wa = par_ff;
               end
               if (depth_ff < DEPTH_W'(POOL_NODES)) begin
                  stack_we = 1'b1;
                  depth_in = depth_ff + 1'b1;
               end
            end
            if (flags.lvl_top) begin
               total_in = total_ff - 1'b1;
            end else begin
               lvl_in = lvl_ff + 1'b1;
               cur_in = par_ff;
            end
         end
         bxt_pkg::OP_EXT_LINK: begin
            if (ext_nx != '0) begin
               if (took != vbit) acc_in[lvl_ff] = 1'b1;
               cur_in = ext_nx;
               if (!flags.lvl_last) lvl_in = lvl_ff - 1'b1;
            end
         end
         bxt_pkg::OP_CNT_LINK: begin
            pend_in  = !kbit && (over != '0);
            tally_ra = over;
            nx_in    = cnt_nx;
         end
         bxt_pkg::OP_CNT_ADD: begin
            if (pend_ff) acc_in = acc_ff + bxt_pkg::WORD_W'(tally_rd_ff);
            tally_ra = nx_ff;
            if (nx_ff != '0) begin
               cur_in = nx_ff;
               if (!flags.lvl_last) lvl_in = lvl_ff - 1'b1;
            end
         end
         bxt_pkg::OP_CNT_FIN: begin
            acc_in = acc_ff + bxt_pkg::WORD_W'(tally_rd_ff);
         end
         bxt_pkg::OP_EMIT: begin
            emit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      low_in = low_ff;
      if (depth_in < low_ff) low_in = depth_in;
   end

   assign top_ra = depth_in[NODE_W-1:0] - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_W'(POOL_NODES - 1);
         low_ff   <= DEPTH_W'(POOL_NODES - 1);
         total_ff <= '0;
         root0_ff <= '0;
         root1_ff <= '0;
         fresh_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         low_ff   <= low_in;
         total_ff <= total_in;
         root0_ff <= root0_in;
         root1_ff <= root1_in;
         fresh_ff <= fresh_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      value_ff <= value_in;
      thr_ff   <= thr_in;
      cur_ff   <= cur_in;
      nx_ff    <= nx_in;
      par_ff   <= par_in;
      lvl_ff   <= lvl_in;
      acc_ff   <= acc_in;
      st_ff    <= st_in;
      if (emit) begin
         out_status_ff <= st_ff;
         out_answer_ff <= acc_ff;
      end
      if (path_we) path_ff[lvl_ff] <= path_wd;
   end

   // node memories
   always_ff @(posedge clock) begin
      if (zero_we) zero_mem[zero_wa] <= zero_wd;
      zero_rd_ff <= zero_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (one_we) one_mem[one_wa] <= one_wd;
      one_rd_ff <= one_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (tally_we) tally_mem[tally_wa] <= tally_wd;
      tally_rd_ff <= tally_mem[tally_ra];
   end

   // free stack, top of stack read with write forwarding
   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_wa] <= stack_wd;
      if (stack_we && stack_wa == top_ra) top_rd_ff <= stack_wd;
      else                                top_rd_ff <= stack_mem[top_ra];
   end

   assign out_status = out_status_ff;
   assign out_answer = out_answer_ff;

endmodule

`default_nettype wire

@@ sv/bxt_controller.sv @@
// bxt_controller: request sequencer and result handshake
// depends on bxt_pkg
`default_nettype none

module bxt_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  bxt_pkg::flags_type flags,
   output bxt_pkg::cmd_type   cmd
);

   typedef enum logic [14:0] {
      S_IDLE      = 15'h0001,
      S_START     = 15'h0002,
      S_INS_LINK  = 15'h0004,
      S_INS_TALLY = 15'h0008,
      S_INS_NEW   = 15'h0010,
      S_REM_LINK  = 15'h0020,
      S_REM_WAIT  = 15'h0040,
      S_REM_UP_RD = 15'h0080,
      S_REM_UP_WR = 15'h0100,
      S_EXT_LINK  = 15'h0200,
      S_EXT_WAIT  = 15'h0400,
      S_CNT_LINK  = 15'h0800,
      S_CNT_ADD   = 15'h1000,
      S_CNT_FIN   = 15'h2000,
      S_DONE      = 15'h4000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = bxt_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = bxt_pkg::OP_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.op = bxt_pkg::OP_CHECK;
            case (flags.req)
               bxt_pkg::REQ_INSERT: state_in = flags.full ? S_DONE : S_INS_LINK;
               bxt_pkg::REQ_REMOVE: state_in = S_REM_LINK;
               bxt_pkg::REQ_MAX,
               bxt_pkg::REQ_MIN:    state_in = flags.empty ? S_DONE : S_EXT_LINK;
               bxt_pkg::REQ_COUNT:  state_in = flags.thr_wide ? S_DONE : S_CNT_LINK;
               default:             state_in = S_DONE;
            endcase
         end
         S_INS_LINK: begin
            cmd.op   = bxt_pkg::OP_INS_LINK;
            state_in = flags.child_null ? S_INS_NEW : S_INS_TALLY;
         end
         S_INS_TALLY: begin
            cmd.op   = bxt_pkg::OP_INS_TALLY;
            state_in = flags.lvl_last ? S_DONE : S_INS_LINK;
         end
         S_INS_NEW: begin
            cmd.op   = bxt_pkg::OP_INS_NEW;
            state_in = flags.lvl_last ? S_DONE : S_INS_LINK;
         end
         S_REM_LINK: begin
            cmd.op = bxt_pkg::OP_REM_LINK;
            if (flags.child_null)    state_in = S_DONE;
            else if (flags.lvl_last) state_in = S_REM_UP_RD;
            else                     state_in = S_REM_WAIT;
         end
         S_REM_WAIT:  state_in = S_REM_LINK;
         S_REM_UP_RD: begin
            cmd.op   = bxt_pkg::OP_REM_UP_RD;
            state_in = S_REM_UP_WR;
         end
         S_REM_UP_WR: begin
            cmd.op   = bxt_pkg::OP_REM_UP_WR;
            state_in = flags.lvl_top ? S_DONE : S_REM_UP_RD;
         end
         S_EXT_LINK: begin
            cmd.op   = bxt_pkg::OP_EXT_LINK;
            state_in = (flags.ext_null || flags.lvl_last) ? S_DONE : S_EXT_WAIT;
         end
         S_EXT_WAIT:  state_in = S_EXT_LINK;
         S_CNT_LINK: begin
            cmd.op   = bxt_pkg::OP_CNT_LINK;
            state_in = S_CNT_ADD;
         end
         S_CNT_ADD: begin
            cmd.op = bxt_pkg::OP_CNT_ADD;
            if (flags.next_null)     state_in = S_DONE;
            else if (flags.lvl_last) state_in = S_CNT_FIN;
            else                     state_in = S_CNT_LINK;
         end
         S_CNT_FIN: begin
            cmd.op   = bxt_pkg::OP_CNT_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.op       = bxt_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/binary_xor_trie_engine.sv @@
// binary_xor_trie_engine: top level of the xor trie, controller plus datapath
// depends on bxt_pkg, bxt_if, bxt_controller, bxt_datapath
//
// usage
//   req_ch carries one request word: req_type (insert, remove, max xor,
//   min xor, count of xor >= threshold), value and threshold
//   rsp_ch returns exactly one word per request: status and answer
//   one request is in flight at a time; req_ch.ready is high only when idle
// walk, from accept to result word
//   each trie level is a link step and then a tally, new node, wait or
//   add step, bounded by the registered read of the node link and tally
//   memories; remove walks down, then back up decrementing tallies in a
//   read and a write step per level; early exits (full, not found, empty,
//   dead branch) finish sooner
// request flow
//   the next request is accepted only once the last has emitted its result
// reset
//   synchronous; empties the store with no clearing pass: the root
//   links and free stack depth are registers, and never-used free stack
//   slots are recognized by a low-water mark
// stall
//   a finished result sits in the output register; the next request is
//   accepted and worked on meanwhile, and waits only at its own result
`default_nettype none

module binary_xor_trie_engine #(
   parameter int KEY_BITS   = bxt_pkg::KEY_BITS_DEF,
   parameter int POOL_NODES = bxt_pkg::POOL_NODES_DEF,
   parameter int TALLY_BITS = bxt_pkg::TALLY_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bxt_req_if.sink    req_ch,
   bxt_rsp_if.source  rsp_ch
);

   bxt_pkg::cmd_type   cmd;
   bxt_pkg::flags_type flags;
   logic               ctl_req_ready;
   logic               ctl_rsp_valid;

   // sequencer: one state per step of a level walk
   bxt_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctl_req_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (ctl_rsp_valid),
      .flags     (flags),
      .cmd       (cmd)
   );

   // node pool, free stack, path stack and result register
   bxt_datapath #(
      .KEY_BITS   (KEY_BITS),
      .POOL_NODES (POOL_NODES),
      .TALLY_BITS (TALLY_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .in_req_type  (req_ch.req_type),
      .in_value     (req_ch.value),
      .in_threshold (req_ch.threshold),
      .flags        (flags),
      .out_status   (rsp_ch.status),
      .out_answer   (rsp_ch.answer)
   );

   assign req_ch.ready = ctl_req_ready;
   assign rsp_ch.valid = ctl_rsp_valid;

endmodule

`default_nettype wire

@@ sv/bxt_checker.sv @@
// bxt_checker: port-level assertions for binary_xor_trie_engine, with its bind
// depends on bxt_pkg and the top level
`default_nettype none

module bxt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_answer
);

   // result word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer) && $stable(rsp_status))
      else $error("result word changed under stall");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one request in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // any error status carries a zero answer
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bxt_pkg::ST_OK |-> rsp_answer == '0)
      else $error("nonzero answer with error status");

endmodule

bind binary_xor_trie_engine bxt_checker u_bxt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_answer (rsp_ch.answer)
);

`default_nettype wire
